### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the deque execution unit (bdqs_back).
// Both macros expand to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BDQS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BDQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BDQS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDQS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/bdqs_pkg.sv
// ---------------------------------------------------------------------------
// bdqs_pkg
// Shared sizes, operation and status codes, and transfer types of the deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdqs_pkg;

   localparam int CAPACITY = 16;
   localparam int WORD_W   = 32;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;

   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;

   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] OP_SEARCH     = 3'd4;
   localparam logic [KIND_W-1:0] OP_NOP        = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] op;
      logic [WORD_W-1:0] value;
   } bdqs_op_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [OCC_W-1:0]  occupancy;
   } bdqs_rsp_type;

endpackage

`default_nettype wire

### rtl/bdqs_ram.sv
// ---------------------------------------------------------------------------
// bdqs_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/bdqs_front.sv
// ---------------------------------------------------------------------------
// bdqs_front
// Accepts requests, maps the kind code to an operation and holds them in a
// short queue until the execution side takes them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdqs_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [bdqs_pkg::KIND_W-1:0] req_kind,
   input  wire logic [bdqs_pkg::WORD_W-1:0] req_value,
   output logic                             op_valid,
   output bdqs_pkg::bdqs_op_type            op_data,
   input  wire logic                        op_take
);
   import bdqs_pkg::*;

   bdqs_op_type          ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 accept;
   logic                 deq;
   bdqs_op_type          classified;

   always_comb begin
      classified.value = req_value;
      unique case (req_kind)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK, OP_SEARCH: begin
            classified.op = req_kind;
         end
         default: begin
            classified.op = OP_NOP;
         end
      endcase
   end

   assign req_full = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign accept   = req_push && !req_full;
   assign op_valid = (cnt_ff != '0);
   assign op_data  = ent_ff[rd_ptr_ff];
   assign deq      = op_valid && op_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !accept) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

### rtl/bdqs_back.sv
// ---------------------------------------------------------------------------
// bdqs_back
// Executes queued operations on the ring of slots. Pushes and pops finish when
// the result queue has room; a search reads one slot per cycle from the front.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bdqs_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   op_valid,
   input  wire bdqs_pkg::bdqs_op_type  op_data,
   output logic                        op_take,
   output logic                        rsp_push,
   output bdqs_pkg::bdqs_rsp_type      rsp_data,
   input  wire logic                   rsp_full
);
   import bdqs_pkg::*;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_WALK = 1'b1;

   logic [0:0]        state_ff, state_in;
   logic [PTR_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [PTR_W-1:0]  cmp_idx_ff, cmp_idx_in;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              rd_en;
   logic [WORD_W-1:0] rd_data;
   logic              is_full;
   logic              is_empty;
   logic [PTR_W-1:0]  front_dec;
   logic [PTR_W-1:0]  front_inc;
   logic [PTR_W-1:0]  tail_addr;
   logic [SUM_W-1:0]  tail_sum;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? PTR_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = ring_inc(front_ff);
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_addr = (tail_sum >= SUM_W'(CAPACITY)) ?
                      PTR_W'(tail_sum - SUM_W'(CAPACITY)) : PTR_W'(tail_sum);

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      rptr_in    = rptr_ff;
      walk_in    = walk_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      wr_en      = 1'b0;
      wr_addr    = front_dec;
      rd_en      = 1'b0;
      op_take    = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = '0;
      unique case (state_ff)
         S_IDLE: begin
            op_take = op_valid && !rsp_full;
            if (op_take) begin
               rsp_push        = 1'b1;
               rsp_data.status = STAT_OK;
               unique case (op_data.op)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_data.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_data.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_addr;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_data.status = STAT_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        rsp_data.status = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (is_empty) begin
                        rsp_data.status = STAT_MISS;
                     end else begin
                        rsp_push = 1'b0;
                        state_in = S_WALK;
                        key_in   = op_data.value;
                        rptr_in  = front_ff;
                        walk_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data.occupancy = OCC_W'(count_in);
            end
         end
         S_WALK: begin
            if (walk_ff != count_ff) begin
               rd_en      = 1'b1;
               rptr_in    = ring_inc(rptr_ff);
               walk_in    = walk_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = PTR_W'(walk_ff);
            end
            if (cmp_vld_ff) begin
               if (rd_data == key_ff) begin
                  rsp_push           = 1'b1;
                  rsp_data.status    = STAT_OK;
                  rsp_data.position  = POS_W'(cmp_idx_ff);
                  rsp_data.occupancy = OCC_W'(count_ff);
                  state_in           = S_IDLE;
                  cmp_vld_in         = 1'b0;
               end else if (CNT_W'(cmp_idx_ff) == count_ff - 1'b1) begin
                  rsp_push           = 1'b1;
                  rsp_data.status    = STAT_MISS;
                  rsp_data.occupancy = OCC_W'(count_ff);
                  state_in           = S_IDLE;
                  cmp_vld_in         = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         front_ff   <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rptr_ff    <= rptr_in;
      walk_ff    <= walk_in;
      cmp_idx_ff <= cmp_idx_in;
   end

   bdqs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (op_data.value),
      .rd_en   (rd_en),
      .rd_addr (rptr_ff),
      .rd_data (rd_data)
   );

   `BDQS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `BDQS_ASSERT_IMPL(a_no_push_when_full, clock, reset, rsp_push, !rsp_full)
   `BDQS_ASSERT_IMPL(a_walk_not_empty, clock, reset, state_ff == S_WALK, count_ff != '0)
   `BDQS_ASSERT_NEXT(a_walk_holds_state, clock, reset, state_ff == S_WALK, $stable(count_ff) && $stable(front_ff))
   `BDQS_ASSERT_IMPL(a_cmp_only_in_walk, clock, reset, cmp_vld_ff, state_ff == S_WALK)

endmodule

`default_nettype wire

### rtl/bdqs_rsp_q.sv
// ---------------------------------------------------------------------------
// bdqs_rsp_q
// Short result queue that decouples execution from the result receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdqs_rsp_q (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bdqs_pkg::bdqs_rsp_type push_data,
   output logic                        full,
   output logic                        empty,
   input  wire logic                   pop,
   output bdqs_pkg::bdqs_rsp_type      head
);
   import bdqs_pkg::*;

   bdqs_rsp_type        ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                enq;
   logic                deq;

   assign full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = ent_ff[rd_ptr_ff];
   assign enq   = push && !full;
   assign deq   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/bounded_deque_with_search_unit.sv
// ---------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Bounded double-ended queue of 32-bit words with a search operation.
//
// Requests enter through a queue-style port: a transfer happens at a rising
// edge with req_push high and req_full low. req_kind selects push front, push
// back, pop front, pop back or search; req_value is the word or search key.
// Each request yields exactly one result, read like a queue: while rsp_empty
// is low the oldest result is on rsp_status, rsp_position and rsp_occupancy,
// and a transfer happens at an edge with rsp_pop high.
// Pushes and pops are done in the execution unit's idle state, so they sustain
// one request per cycle while the result side drains and no search runs.
// A search reads one slot per cycle from the single RAM read port, from the
// front onward, and ends at the first match or after the last stored word.
// Two-entry queues sit on both sides of the execution unit. When the result
// side is not drained, execution halts and the request queue fills, raising
// req_full. Reset empties the store and both queues; slot contents are not
// cleared, and only occupied slots are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [bdqs_pkg::KIND_W-1:0] req_kind,
   input  wire logic signed [bdqs_pkg::WORD_W-1:0] req_value,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [bdqs_pkg::STAT_W-1:0]      rsp_status,
   output logic [bdqs_pkg::POS_W-1:0]       rsp_position,
   output logic [bdqs_pkg::OCC_W-1:0]       rsp_occupancy
);
   import bdqs_pkg::*;

   logic         op_valid;
   bdqs_op_type  op_data;
   logic         op_take;
   logic         back_push;
   bdqs_rsp_type back_data;
   logic         back_full;
   bdqs_rsp_type head;

   bdqs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_kind  (req_kind),
      .req_value (WORD_W'(req_value)),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_take   (op_take)
   );

   bdqs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_data  (op_data),
      .op_take  (op_take),
      .rsp_push (back_push),
      .rsp_data (back_data),
      .rsp_full (back_full)
   );

   bdqs_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .full      (back_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (head)
   );

   assign rsp_status    = head.status;
   assign rsp_position  = head.position;
   assign rsp_occupancy = head.occupancy;

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the bounded deque with search against an in-bench prediction of
// the store. A short table exercises the empty, full, single-word, extreme
// and unused-code cases, then biased random traffic fills, drains and searches
// the store; both sides of the block stall in random bursts until the last items.
// ---------------------------------------------------------------------------

module testbench;
   import bdqs_pkg::*;

   localparam logic [KIND_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_ITEMS  = 80;
   localparam int HOLD_POINT   = 250;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SCRIPT_ROWS  = 18;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      int                reps;
      bit                typed;
      bdqs_rsp_type      rsp;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [KIND_W-1:0]   req_kind = OP_NOP;
   logic [WORD_W-1:0]   req_value = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [POS_W-1:0]    rsp_position;
   logic [OCC_W-1:0]    rsp_occupancy;

   logic [WORD_W-1:0]   ring_words [CAPACITY];
   logic [PTR_W-1:0]    head_slot = '0;
   logic [CNT_W-1:0]    word_count = '0;
   bdqs_rsp_type        replies_due [$];
   stim_row_type        script [SCRIPT_ROWS];
   logic [WORD_W-1:0]   word_pool [6];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  quiet = 1'b0;

   bounded_deque_with_search_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   function automatic bdqs_rsp_type apply_deque_op(input logic [KIND_W-1:0] kind,
                                                   input logic [WORD_W-1:0] word);
      bdqs_rsp_type     reply;
      logic [PTR_W-1:0] slot;
      reply.status   = STAT_OK;
      reply.position = '0;
      case (kind)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (word_count == CAPACITY) begin
               reply.status = STAT_FULL;
            end else if (kind == OP_PUSH_FRONT) begin
               head_slot = head_slot - 1'b1;
               ring_words[head_slot] = word;
               word_count = word_count + 1'b1;
            end else begin
               slot = head_slot + word_count[PTR_W-1:0];
               ring_words[slot] = word;
               word_count = word_count + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (word_count == 0) begin
               reply.status = STAT_EMPTY;
            end else begin
               if (kind == OP_POP_FRONT) head_slot = head_slot + 1'b1;
               word_count = word_count - 1'b1;
            end
         end
         OP_SEARCH: begin
            reply.status = STAT_MISS;
            for (int i = 0; i < word_count; i++) begin
               slot = head_slot + i[PTR_W-1:0];
               if (reply.status == STAT_MISS && ring_words[slot] == word) begin
                  reply.status   = STAT_OK;
                  reply.position = i[POS_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      reply.occupancy = word_count;
      return reply;
   endfunction

   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word,
                               input bit typed, input bdqs_rsp_type typed_rsp);
      bdqs_rsp_type predicted;
      req_push  <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      do @(posedge clock); while (req_full);
      predicted = apply_deque_op(kind, word);
      replies_due.push_back(typed ? typed_rsp : predicted);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 9) < 4) return word_pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   function automatic logic [WORD_W-1:0] pick_key();
      logic [PTR_W-1:0] slot;
      if (word_count != 0 && $urandom_range(0, 1) == 1) begin
         slot = head_slot + PTR_W'($urandom_range(0, word_count - 1));
         return ring_words[slot];
      end
      return pick_word();
   endfunction

   task automatic check_reply();
      bdqs_rsp_type want;
      if (replies_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: status %0d position %0d occupancy %0d",
                     rsp_status, rsp_position, rsp_occupancy);
      end else begin
         want = replies_due.pop_front();
         if (rsp_status !== want.status || rsp_position !== want.position ||
             rsp_occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want.status, want.position, want.occupancy,
                        rsp_status, rsp_position, rsp_occupancy);
         end
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) check_reply();
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int                regime;
      int                roll;
      int                push_weight;
      int                pop_weight;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;

      word_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001, 32'h5A5A_A5A5};
      script = '{
         '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{STAT_EMPTY, 4'd0, 5'd0}},
         '{OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, '{STAT_EMPTY, 4'd0, 5'd0}},
         '{OP_SEARCH,     32'h0000_0000, 1,  1'b1, '{STAT_MISS,  4'd0, 5'd0}},
         '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, '{STAT_OK,    4'd0, 5'd1}},
         '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, '{STAT_OK,    4'd0, 5'd2}},
         '{OP_SEARCH,     32'h8000_0000, 1,  1'b1, '{STAT_OK,    4'd0, 5'd2}},
         '{OP_SEARCH,     32'h7FFF_FFFF, 1,  1'b1, '{STAT_OK,    4'd1, 5'd2}},
         '{OP_SEARCH,     32'h0000_0000, 1,  1'b1, '{STAT_MISS,  4'd0, 5'd2}},
         '{OP_NOP,        32'h1234_5678, 1,  1'b1, '{STAT_OK,    4'd0, 5'd2}},
         '{OP_UNUSED_HI,  32'hFFFF_FFFF, 1,  1'b1, '{STAT_OK,    4'd0, 5'd2}},
         '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, '{STAT_OK,    4'd0, 5'd1}},
         '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, '{STAT_OK,    4'd0, 5'd0}},
         '{OP_PUSH_BACK,  32'h5555_5555, 15, 1'b0, '{STAT_OK,    4'd0, 5'd0}},
         '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1,  1'b1, '{STAT_OK,    4'd0, 5'd16}},
         '{OP_PUSH_FRONT, 32'h0000_0001, 1,  1'b1, '{STAT_FULL,  4'd0, 5'd16}},
         '{OP_PUSH_BACK,  32'h0000_0002, 1,  1'b1, '{STAT_FULL,  4'd0, 5'd16}},
         '{OP_SEARCH,     32'h5555_5563, 1,  1'b1, '{STAT_OK,    4'd15, 5'd16}},
         '{OP_SEARCH,     32'hAAAA_AAAA, 1,  1'b1, '{STAT_OK,    4'd0, 5'd16}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++)
            send_request(script[r].kind, script[r].value + k, script[r].typed, script[r].rsp);
      end

      regime = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 24 == 0) regime = $urandom_range(0, 3);
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         if (n == HOLD_POINT && replies_due.size() != 0) begin
            req_push <= 1'b0;
            while (replies_due.size() != 0) @(posedge clock);
         end
         case (regime)
            0:       begin push_weight = 70; pop_weight = 15; end
            1:       begin push_weight = 15; pop_weight = 70; end
            2:       begin push_weight = 40; pop_weight = 40; end
            default: begin push_weight = 25; pop_weight = 25; end
         endcase
         roll = $urandom_range(0, 99);
         word = pick_word();
         if (roll < 3) begin
            kind = KIND_W'($urandom_range(OP_NOP, OP_UNUSED_HI));
            word = $urandom;
         end else if (roll < 3 + push_weight) begin
            kind = ($urandom_range(0, 1) == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else if (roll < 3 + push_weight + pop_weight) begin
            kind = ($urandom_range(0, 1) == 1) ? OP_POP_FRONT : OP_POP_BACK;
            word = $urandom;
         end else begin
            kind = OP_SEARCH;
            word = pick_key();
         end
         send_request(kind, word, 1'b0, '{STAT_OK, 4'd0, 5'd0});
      end

      req_push <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);

      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/bdqs_pkg.sv
rtl/bdqs_ram.sv
rtl/bdqs_front.sv
rtl/bdqs_back.sv
rtl/bdqs_rsp_q.sv
rtl/bounded_deque_with_search_unit.sv
sim/testbench.sv
